### rtl/three_flavor_survival_probability_assert.svh
// ----------------------------------------------------------------------------
// Survival probability assertion macros
// Shared property wrappers used by the modules of the survival block.
// ----------------------------------------------------------------------------
`ifndef THREE_FLAVOR_SURVIVAL_PROBABILITY_ASSERT_SVH
`define THREE_FLAVOR_SURVIVAL_PROBABILITY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TFSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tfsp_pkg.sv
// ----------------------------------------------------------------------------
// Survival probability package
// Field widths, arithmetic constants, series tables and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfsp_pkg;

	// Field and register widths.
	localparam int ENERGY_W    = 24;
	localparam int SURV_W      = 25;
	localparam int OUT_TDATA_W = 32;
	localparam int BASE_W      = 20;
	localparam int MIX_W       = 25;
	localparam int SPLIT_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Default fraction width of the internal fixed-point values.
	localparam int FRAC_BITS_DEF = 24;

	// Phase division: 52-bit numerator shifted up by 12, one quotient bit a stage.
	localparam int NUM_W     = 52;
	localparam int NUM_SHIFT = 12;
	localparam int DIV_BITS  = 64;

	// Number of nested series factors in the sine approximation.
	localparam int SERIES_TERMS = 5;

	// Lane depth: numerator, divider, six phase stages, series, two output stages.
	localparam int LANE_LAT = 1 + DIV_BITS + 6 + 3 * SERIES_TERMS + 2;

	// Depth of the queue between the front end and the datapath.
	localparam int QUEUE_DEPTH = 2;

	// 1.267/pi in Q32 and pi in Q30.
	localparam logic [30:0] PHASE_K = 31'd1732154408;
	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [32:0] ONE_32  = 33'h1_0000_0000;

	// Mixing value of one in Q24.
	localparam logic [MIX_W-1:0] MIX_ONE = 25'h100_0000;

	// Reset values of the configuration registers.
	localparam logic [BASE_W-1:0]  BASELINE_RST = 20'd52500;
	localparam logic [MIX_W-1:0]   MIX_12_RST   = 25'd4982833;
	localparam logic [MIX_W-1:0]   MIX_13_RST   = 25'd359032;
	localparam logic [SPLIT_W-1:0] SPLIT_21_RST = 32'd5064625;
	localparam logic [SPLIT_W-1:0] SPLIT_31_RST = 32'd174331005;
	localparam logic [SPLIT_W-1:0] SPLIT_32_RST = 32'd169266379;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASELINE = 3'd0,
		REG_MIX_12   = 3'd1,
		REG_MIX_13   = 3'd2,
		REG_SPLIT_21 = 3'd3,
		REG_SPLIT_31 = 3'd4,
		REG_SPLIT_32 = 3'd5
	} reg_idx_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [BASE_W-1:0]  baseline;
		logic [MIX_W-1:0]   mix_12;
		logic [MIX_W-1:0]   mix_13;
		logic [SPLIT_W-1:0] split_21;
		logic [SPLIT_W-1:0] split_31;
		logic [SPLIT_W-1:0] split_32;
	} cfg_t;

	// Forward half of an internal item channel; ready runs the other way.
	typedef struct packed {
		logic                valid;
		logic [ENERGY_W-1:0] energy;
	} stream_t;

	// Divisors of the nested sine series, innermost first.
	function automatic logic [7:0] series_div(input int idx);
		case (idx)
			0:       return 8'd110;
			1:       return 8'd72;
			2:       return 8'd42;
			3:       return 8'd20;
			default: return 8'd6;
		endcase
	endfunction

	// floor(2^36 / divisor): the estimate is low by at most one.
	function automatic logic [33:0] series_recip(input int idx);
		case (idx)
			0:       return 34'd624722515;
			1:       return 34'd954437176;
			2:       return 34'd1636178017;
			3:       return 34'd3435973836;
			default: return 34'd11453246122;
		endcase
	endfunction

endpackage

### rtl/three_flavor_survival_probability.sv
// ----------------------------------------------------------------------------
// Three-flavor survival probability
// Survival probability 1 - sum of three weighted sin^2 terms per energy item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s_axis    in         s_tvalid / s_tready    s_tdata[23:0]  energy
//  m_axis    out        m_tvalid / m_tready    m_tdata[24:0]  survival
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
//  One item per cycle sustained while the output is not stalled; m_tvalid
//  rises once the item has passed the input register, the queue, 88 lane stages
//  (64 of them in the phase divider, one quotient bit a stage), the weighted
//  terms and the output register. Reset clears the valid flags and loads the
//  register reset values; no memory needs clearing. A stall at the output
//  freezes the datapath; the input register and the two-entry queue keep
//  taking items until they hold three between them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_flavor_survival_probability #(
	parameter int FRAC_BITS = tfsp_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tfsp_pkg::ENERGY_W-1:0]    s_tdata,   // [23:0] energy
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tfsp_pkg::OUT_TDATA_W-1:0] m_tdata,   // [24:0] survival, rest zero
	input  logic                             cfg_we,
	input  logic [tfsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tfsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tfsp_pkg::*;

	cfg_t              cfg_q;
	stream_t           front_out;
	logic              queue_ready;
	stream_t           queue_out;
	logic              back_ready;
	logic [SURV_W-1:0] survival;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.baseline <= BASELINE_RST;
			cfg_q.mix_12   <= MIX_12_RST;
			cfg_q.mix_13   <= MIX_13_RST;
			cfg_q.split_21 <= SPLIT_21_RST;
			cfg_q.split_31 <= SPLIT_31_RST;
			cfg_q.split_32 <= SPLIT_32_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASELINE: cfg_q.baseline <= cfg_data[BASE_W-1:0];
				REG_MIX_12:   cfg_q.mix_12   <= cfg_data[MIX_W-1:0];
				REG_MIX_13:   cfg_q.mix_13   <= cfg_data[MIX_W-1:0];
				REG_SPLIT_21: cfg_q.split_21 <= cfg_data[SPLIT_W-1:0];
				REG_SPLIT_31: cfg_q.split_31 <= cfg_data[SPLIT_W-1:0];
				REG_SPLIT_32: cfg_q.split_32 <= cfg_data[SPLIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input side.
	tfsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out      (front_out),
		.out_ready(queue_ready)
	);

	// Decoupling queue.
	tfsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (front_out),
		.in_ready (queue_ready),
		.out      (queue_out),
		.out_ready(back_ready)
	);

	// Arithmetic datapath.
	tfsp_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in      (queue_out),
		.in_ready(back_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.survival(survival)
	);

	assign m_tdata = {(OUT_TDATA_W - SURV_W)'(0), survival};

endmodule

### rtl/tfsp_front.sv
// ----------------------------------------------------------------------------
// Survival probability front end
// Accepts energy items and maps a zero energy to the smallest energy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfsp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tfsp_pkg::ENERGY_W-1:0] s_tdata,
	output tfsp_pkg::stream_t             out,
	input  logic                          out_ready
);
	import tfsp_pkg::*;

	logic                valid_q;
	logic [ENERGY_W-1:0] energy_q;

	// The slot frees up whenever the queue takes the held item.
	assign s_tready = !valid_q || out_ready;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	// A zero energy is treated as one unit.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			energy_q <= (s_tdata == '0) ? ENERGY_W'(1) : s_tdata;
		end
	end

	assign out.valid  = valid_q;
	assign out.energy = energy_q;

endmodule

### rtl/tfsp_queue.sv
// ----------------------------------------------------------------------------
// Survival probability item queue
// Short first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_flavor_survival_probability_assert.svh"

module tfsp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  tfsp_pkg::stream_t in,
	output logic              in_ready,
	output tfsp_pkg::stream_t out,
	input  logic              out_ready
);
	import tfsp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ENERGY_W-1:0] slot_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push;
	logic                pop;

	assign in_ready   = (count_q != CNT_W'(QUEUE_DEPTH));
	assign out.valid  = (count_q != '0);
	assign out.energy = slot_q[rd_ptr_q];
	assign push       = in.valid && in_ready;
	assign pop        = out.valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in.energy;
		end
	end

	`TFSP_ASSERT_NEXT(a_q_fill, clk, arst_n, push && !pop, count_q == $past(count_q) + CNT_W'(1), "queue fill count did not grow on a lone push")
	`TFSP_ASSERT_NEXT(a_q_drain, clk, arst_n, pop && !push, count_q == $past(count_q) - CNT_W'(1), "queue fill count did not shrink on a lone pop")

endmodule

### rtl/tfsp_lane.sv
// ----------------------------------------------------------------------------
// Survival probability phase lane
// Computes sin^2 of one oscillation phase for a stream of energies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfsp_lane #(
	parameter int FRAC_BITS = tfsp_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tfsp_pkg::SPLIT_W-1:0]  split,
	input  logic [tfsp_pkg::BASE_W-1:0]   baseline,
	input  logic [tfsp_pkg::ENERGY_W-1:0] energy,
	output logic [FRAC_BITS:0]            sin_sq
);
	import tfsp_pkg::*;

	localparam int QW = FRAC_BITS + 1;

	// Numerator and divider stages.
	logic [SPLIT_W-1:0]  mag;
	logic [NUM_W-1:0]    num;
	logic [DIV_BITS-1:0] work_s [0:DIV_BITS];
	logic [ENERGY_W-1:0] rem_s  [0:DIV_BITS-1];
	logic [ENERGY_W-1:0] den_s  [0:DIV_BITS-1];
	logic [ENERGY_W:0]   cand   [0:DIV_BITS-1];
	logic                ge     [0:DIV_BITS-1];
	logic [ENERGY_W-1:0] nrem   [0:DIV_BITS-2];

	// Phase and reduction stages.
	logic [62:0] plo;
	logic [62:0] phi;
	logic [62:0] plo_s;
	logic [31:0] phi_s;
	logic [63:0] f_s;
	logic [63:0] g_s;
	logic        fold;
	logic [63:0] h;
	logic [30:0] hh_s;
	logic        flip_h_s;
	logic [62:0] px;
	logic [31:0] x_d_s;
	logic        flip_d_s;
	logic [63:0] px2;

	// Series stages.
	logic [31:0] it_x    [0:SERIES_TERMS];
	logic [31:0] it_x2   [0:SERIES_TERMS-1];
	logic [32:0] it_r    [0:SERIES_TERMS];
	logic        it_flip [0:SERIES_TERMS];
	logic [64:0] pa      [0:SERIES_TERMS-1];
	logic [31:0] a_p     [0:SERIES_TERMS-1];
	logic [31:0] a_x     [0:SERIES_TERMS-1];
	logic [31:0] a_x2    [0:SERIES_TERMS-1];
	logic        a_flip  [0:SERIES_TERMS-1];
	logic [65:0] pb      [0:SERIES_TERMS-1];
	logic [29:0] b_q     [0:SERIES_TERMS-1];
	logic [31:0] b_p     [0:SERIES_TERMS-1];
	logic [31:0] b_x     [0:SERIES_TERMS-1];
	logic [31:0] b_x2    [0:SERIES_TERMS-1];
	logic        b_flip  [0:SERIES_TERMS-1];
	logic [7:0]  rem8    [0:SERIES_TERMS-1];
	logic [31:0] qfix    [0:SERIES_TERMS-1];

	// Output stages.
	logic [64:0] ps;
	logic [31:0] s_s;
	logic        flip_s_s;
	logic [63:0] psq;
	logic [32:0] sq_v;

	// Magnitude of the splitting; sin^2 is even in the phase.
	assign mag = split[SPLIT_W-1] ? (~split + SPLIT_W'(1)) : split;
	assign num = NUM_W'(mag) * NUM_W'(baseline);

	// One restoring division step per stage.
	always_comb begin
		for (int i = 0; i < DIV_BITS; i++) begin
			cand[i] = {rem_s[i], work_s[i][DIV_BITS-1]};
			ge[i]   = (cand[i] >= {1'b0, den_s[i]});
		end
		for (int i = 0; i < DIV_BITS - 1; i++) begin
			nrem[i] = ge[i] ? ENERGY_W'(cand[i] - {1'b0, den_s[i]}) : cand[i][ENERGY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s[0] <= {num, NUM_SHIFT'(0)};
			rem_s[0]  <= '0;
			den_s[0]  <= energy;
			for (int i = 0; i < DIV_BITS; i++) begin
				work_s[i+1] <= {work_s[i][DIV_BITS-2:0], ge[i]};
			end
			for (int i = 0; i < DIV_BITS - 1; i++) begin
				rem_s[i+1] <= nrem[i];
				den_s[i+1] <= den_s[i];
			end
		end
	end

	// Phase in half-turns: quotient times 1.267/pi, split into two products.
	assign plo = 63'(work_s[DIV_BITS][31:0]) * 63'(PHASE_K);
	assign phi = 63'(work_s[DIV_BITS][63:32]) * 63'(PHASE_K);

	// Fold the phase into the first quarter turn.
	assign fold = (g_s > 64'h4000_0000_0000_0000);
	assign h    = fold ? (64'h8000_0000_0000_0000 - g_s) : g_s;
	assign px   = 63'(hh_s) * 63'(PI_Q30);
	assign px2  = 64'(x_d_s) * 64'(x_d_s);

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s      <= plo;
			phi_s      <= phi[31:0];
			f_s        <= 64'(plo_s) + {phi_s, 32'd0};
			g_s        <= f_s[63] ? (~f_s + 64'd1) : f_s;
			hh_s       <= h[62:32];
			flip_h_s   <= fold;
			x_d_s      <= px[61:30];
			flip_d_s   <= flip_h_s;
			it_x[0]    <= x_d_s;
			it_x2[0]   <= px2[63:32];
			it_r[0]    <= ONE_32;
			it_flip[0] <= flip_d_s;
		end
	end

	// Nested series r = 1 - x^2*r/d, three stages per factor.
	always_comb begin
		for (int j = 0; j < SERIES_TERMS; j++) begin
			pa[j]   = 65'(it_x2[j]) * 65'(it_r[j]);
			pb[j]   = 66'(a_p[j]) * 66'(series_recip(j));
			rem8[j] = b_p[j][7:0] - 8'(b_q[j][7:0] * series_div(j));
			qfix[j] = (rem8[j] >= series_div(j)) ? 32'(b_q[j]) + 32'd1 : 32'(b_q[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < SERIES_TERMS; j++) begin
				a_p[j]       <= pa[j][63:32];
				a_x[j]       <= it_x[j];
				a_x2[j]      <= it_x2[j];
				a_flip[j]    <= it_flip[j];
				b_q[j]       <= pb[j][65:36];
				b_p[j]       <= a_p[j];
				b_x[j]       <= a_x[j];
				b_x2[j]      <= a_x2[j];
				b_flip[j]    <= a_flip[j];
				it_r[j+1]    <= ONE_32 - 33'(qfix[j]);
				it_x[j+1]    <= b_x[j];
				it_flip[j+1] <= b_flip[j];
			end
			for (int j = 0; j < SERIES_TERMS - 1; j++) begin
				it_x2[j+1] <= b_x2[j];
			end
		end
	end

	// Sine, its square, and the quarter-turn fold back.
	assign ps   = 65'(it_x[SERIES_TERMS]) * 65'(it_r[SERIES_TERMS]);
	assign psq  = 64'(s_s) * 64'(s_s);
	assign sq_v = flip_s_s ? (ONE_32 - 33'(psq[63:32])) : 33'(psq[63:32]);

	always_ff @(posedge clk) begin
		if (en) begin
			s_s      <= ps[63:32];
			flip_s_s <= it_flip[SERIES_TERMS];
			sin_sq   <= QW'(sq_v >> (32 - FRAC_BITS));
		end
	end

endmodule

### rtl/tfsp_back.sv
// ----------------------------------------------------------------------------
// Survival probability datapath
// Three phase lanes, mixing weights, weighted sum and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_flavor_survival_probability_assert.svh"

module tfsp_back #(
	parameter int FRAC_BITS = tfsp_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tfsp_pkg::cfg_t              cfg,
	input  tfsp_pkg::stream_t           in,
	output logic                        in_ready,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tfsp_pkg::SURV_W-1:0] survival
);
	import tfsp_pkg::*;

	localparam int QW     = FRAC_BITS + 1;
	localparam int UPSH   = (FRAC_BITS >= 24) ? (FRAC_BITS - 24) : 0;
	localparam int DNSH   = (FRAC_BITS < 24) ? (24 - FRAC_BITS) : 0;
	localparam int WIDE_W = MIX_W + UPSH;
	localparam int OW     = QW + DNSH;
	localparam int TOT_W  = QW + 2;
	localparam logic [QW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

	logic                en;
	logic [LANE_LAT-1:0] vld_q;
	logic                vt_s;
	logic                vo_q;
	logic [SPLIT_W-1:0]  split [0:2];
	logic [QW-1:0]       sin_v [0:2];
	logic [QW-1:0]       w     [0:2];
	logic [QW-1:0]       t_s   [0:2];
	logic [QW-1:0]       s12_q;
	logic [QW-1:0]       s13_q;
	logic [QW-1:0]       c12;
	logic [QW-1:0]       c13;
	logic [QW-1:0]       m12_q;
	logic [QW-1:0]       m13_q;
	logic [QW-1:0]       c4_q;
	logic [TOT_W-1:0]    tot;
	logic [QW-1:0]       res;
	logic [OW-1:0]       res_w;
	logic [SURV_W-1:0]   surv_q;

	// Fixed-point product with truncation.
	function automatic logic [QW-1:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [2*QW-1:0] p;
		p = (2*QW)'(a) * (2*QW)'(b);
		return QW'(p >> FRAC_BITS);
	endfunction

	// Q24 mixing value, clamped to one, rescaled to the internal format.
	function automatic logic [QW-1:0] mixq(input logic [MIX_W-1:0] m);
		logic [MIX_W-1:0]  sat;
		logic [WIDE_W-1:0] wide;
		sat  = (m > MIX_ONE) ? MIX_ONE : m;
		wide = WIDE_W'(sat) << UPSH;
		return QW'(wide >> DNSH);
	endfunction

	// The whole pipeline moves unless a finished item waits at the output.
	assign en       = !vo_q || m_tready;
	assign in_ready = en;

	// Item valid flags along the lanes and the two closing stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vt_s  <= 1'b0;
			vo_q  <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_LAT-2:0], in.valid};
			vt_s  <= vld_q[LANE_LAT-1];
			vo_q  <= vt_s;
		end
	end

	// Mixing weights follow the registers; they settle long before any item arrives.
	assign c12 = ONE_Q - s12_q;
	assign c13 = ONE_Q - s13_q;

	always_ff @(posedge clk) begin
		s12_q <= mixq(cfg.mix_12);
		s13_q <= mixq(cfg.mix_13);
		m12_q <= mulq(s12_q, c12);
		m13_q <= mulq(s13_q, c13);
		c4_q  <= mulq(c13, c13);
		w[0]  <= mulq(QW'({m12_q, 2'b00}), c4_q);
		w[1]  <= mulq(QW'({m13_q, 2'b00}), c12);
		w[2]  <= mulq(QW'({m13_q, 2'b00}), s12_q);
	end

	// One lane per mass splitting.
	assign split[0] = cfg.split_21;
	assign split[1] = cfg.split_31;
	assign split[2] = cfg.split_32;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		tfsp_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.en      (en),
			.split   (split[k]),
			.baseline(cfg.baseline),
			.energy  (in.energy),
			.sin_sq  (sin_v[k])
		);
	end

	// Weighted terms, then the saturating sum.
	assign tot   = TOT_W'(t_s[0]) + TOT_W'(t_s[1]) + TOT_W'(t_s[2]);
	assign res   = (tot >= TOT_W'(ONE_Q)) ? '0 : QW'(TOT_W'(ONE_Q) - tot);
	assign res_w = OW'(res) << DNSH;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t_s[k] <= mulq(w[k], sin_v[k]);
			end
			surv_q <= SURV_W'(res_w >> UPSH);
		end
	end

	assign m_tvalid = vo_q;
	assign survival = surv_q;

	`TFSP_ASSERT_NEXT(a_back_adv, clk, arst_n, en, vo_q == $past(vt_s), "output valid did not follow the sum stage")
	`TFSP_ASSERT_NEXT(a_back_hold, clk, arst_n, !en, $stable(vld_q), "lane valid flags moved during a stall")

endmodule
